// ===== hdl/cat_pkg.sv =====
package cat_pkg;

   typedef logic signed [31:0] coord_type;
   typedef logic [31:0]        tick_type;
   typedef logic [15:0]        ttl_type;
   typedef logic [3:0]         kind_type;
   typedef logic [2:0]         status_type;
   typedef logic [4:0]         slot_type;
   typedef logic [5:0]         count_type;
   typedef logic [7:0]         alpha_type;
   typedef logic [15:0]        fade_type;

   // result status codes
   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_REFRESHED = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_LISTED    = 3'd3;
   localparam status_type ST_EMPTY     = 3'd4;

   // control register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ALPHA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ALPHA  = 2'd2;

   localparam fade_type  FADE_TICKS_RST = 16'd64;
   localparam alpha_type BASE_ALPHA_RST = 8'd90;
   localparam alpha_type MIN_ALPHA_RST  = 8'd10;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      kind_type  kind;
      tick_type  expiry;
   } entry_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
      count_type  entry_count;
      coord_type  out_x;
      coord_type  out_y;
      coord_type  out_z;
      kind_type   out_kind;
      alpha_type  alpha;
      logic       last;
   } rsp_type;

endpackage

// ===== hdl/cat_if.sv =====
interface cat_req_if;
   logic                valid;
   logic                ready;
   logic                cmd;
   cat_pkg::tick_type   now;
   cat_pkg::coord_type  pos_x;
   cat_pkg::coord_type  pos_y;
   cat_pkg::coord_type  pos_z;
   cat_pkg::kind_type   contact_kind;
   cat_pkg::ttl_type    ttl;

   modport source (output valid, cmd, now, pos_x, pos_y, pos_z, contact_kind, ttl,
                   input ready);
   modport sink   (input valid, cmd, now, pos_x, pos_y, pos_z, contact_kind, ttl,
                   output ready);
endinterface

interface cat_rsp_if;
   logic                 valid;
   logic                 ready;
   cat_pkg::status_type  status;
   cat_pkg::slot_type    slot;
   cat_pkg::count_type   entry_count;
   cat_pkg::coord_type   out_x;
   cat_pkg::coord_type   out_y;
   cat_pkg::coord_type   out_z;
   cat_pkg::kind_type    out_kind;
   cat_pkg::alpha_type   alpha;
   logic                 last;

   modport source (output valid, status, slot, entry_count, out_x, out_y, out_z,
                   out_kind, alpha, last, input ready);
   modport sink   (input valid, status, slot, entry_count, out_x, out_y, out_z,
                   out_kind, alpha, last, output ready);
endinterface

// ===== hdl/contact_aging_table.sv =====
// Contact table with time-to-live expiry. A request with cmd 0 adds a contact
// or refreshes the expiry (now + ttl, saturating) of an entry at exactly the
// same position; a full table drops the add. A request with cmd 1 lists every
// entry in table order with a fade alpha and then removes the expired entries
// (now >= expiry) by moving the last entry into the freed slot; the final
// listing carries last = 1 and the entry count after removal. An empty table
// answers a sweep with a single "empty" transfer. One request is worked on at
// a time and req ready is low until its last result is loaded into the output
// register. All entries sit in one memory with a single registered read port,
// so each entry visited is read in one state and used in the next. An add
// reads and compares the entries in turn until a match or the append (a full
// table drops the add without a scan). A sweep starts, then lists each entry
// by reading it and checking its fade window; inside the window it takes one
// 8-bit x 16-bit multiply, then an 8-step restoring divider resolving one
// alpha bit per cycle. The expiry pass then reads and checks each entry,
// moves the last entry over each expired one, and closes by sending the final
// listing. Output stalls hold the sequencer in its sending states.
// Entries never written read as undefined, but only entries below the live
// count are ever visited, so no clearing pass is needed after reset.
module contact_aging_table #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   cat_req_if.sink                         req_if,
   cat_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [cat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cat_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ADD_FULL = 4'd1;   // drop add, table full
   localparam logic [3:0] S_ADD_SCAN = 4'd2;   // issue read for position compare
   localparam logic [3:0] S_ADD_CMP  = 4'd3;   // compare position
   localparam logic [3:0] S_ADD_INS  = 4'd4;   // append new entry
   localparam logic [3:0] S_SW_START = 4'd5;
   localparam logic [3:0] S_LS_RD    = 4'd6;   // issue read for listing
   localparam logic [3:0] S_LS_D     = 4'd7;   // time to expiry, window check
   localparam logic [3:0] S_LS_MUL   = 4'd8;   // base_alpha * d
   localparam logic [3:0] S_LS_DIV   = 4'd9;   // one quotient bit per cycle
   localparam logic [3:0] S_LS_OUT   = 4'd10;  // floor and send listing
   localparam logic [3:0] S_RM_RD    = 4'd11;  // issue read for expiry check
   localparam logic [3:0] S_RM_CHK   = 4'd12;  // expired? then read last entry
   localparam logic [3:0] S_RM_WR    = 4'd13;  // move last entry into the hole
   localparam logic [3:0] S_FINAL    = 4'd14;  // send final listing

   // ---------------------------------------------------------------- storage
   cat_pkg::entry_type entry_mem [MAX_ENTRIES];
   cat_pkg::entry_type rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   cat_pkg::entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // ---------------------------------------------------------------- control registers
   cat_pkg::fade_type  fade_ticks_ff;
   cat_pkg::alpha_type base_alpha_ff;
   cat_pkg::alpha_type min_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ticks_ff <= cat_pkg::FADE_TICKS_RST;
         base_alpha_ff <= cat_pkg::BASE_ALPHA_RST;
         min_alpha_ff  <= cat_pkg::MIN_ALPHA_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cat_pkg::CSR_FADE_TICKS: fade_ticks_ff <= csr_wdata;
            cat_pkg::CSR_BASE_ALPHA: base_alpha_ff <= csr_wdata[7:0];
            cat_pkg::CSR_MIN_ALPHA:  min_alpha_ff  <= csr_wdata[7:0];
            default: ;   // unmapped index, write ignored
         endcase
      end
   end

   // a fade window of zero behaves as one tick
   cat_pkg::fade_type fade_eff;
   assign fade_eff = (fade_ticks_ff == '0) ? 16'd1 : fade_ticks_ff;

   // ---------------------------------------------------------------- sequencer state
   logic [3:0]          state_ff,     state_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [CNT_W-1:0]    idx_ff,       idx_in;
   cat_pkg::tick_type   now_ff,       now_in;
   cat_pkg::coord_type  px_ff,        px_in;
   cat_pkg::coord_type  py_ff,        py_in;
   cat_pkg::coord_type  pz_ff,        pz_in;
   cat_pkg::kind_type   kind_ff,      kind_in;
   cat_pkg::tick_type   exp_ff,       exp_in;
   cat_pkg::entry_type  entry_ff,     entry_in;     // entry being listed
   logic [15:0]         d_ff,         d_in;         // ticks to expiry, in window
   logic [23:0]         rem_ff,       rem_in;       // divider remainder
   logic [7:0]          quo_ff,       quo_in;       // divider quotient
   logic [2:0]          bit_ff,       bit_in;       // quotient bit in work
   logic                fading_ff,    fading_in;
   cat_pkg::alpha_type  alpha_ff,     alpha_in;     // alpha of final listing
   logic [IDX_W-1:0]    last_slot_ff, last_slot_in;
   cat_pkg::rsp_type    rsp_ff,       rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                out_free;
   logic [32:0]         exp_sum;
   logic [31:0]         diff;
   logic [31:0]         d_full;
   logic [23:0]         trial;
   logic                trial_ge;
   cat_pkg::alpha_type  alpha_now;
   logic                pos_match;
   logic                expired;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   // saturating expiry sum, taken at the request transfer
   assign exp_sum = {1'b0, req_if.now} + 33'(req_if.ttl);

   // ticks left before expiry, zero once expired
   assign diff   = rd_data_ff.expiry - now_ff;
   assign d_full = (rd_data_ff.expiry > now_ff) ? diff : 32'd0;

   // restoring divider step: compare and subtract fade_ticks << bit
   assign trial    = 24'(fade_eff) << bit_ff;
   assign trial_ge = (rem_ff >= trial);

   assign alpha_now = (fading_ff && (quo_ff < min_alpha_ff)) ? min_alpha_ff : quo_ff;

   assign pos_match = (rd_data_ff.x == px_ff) && (rd_data_ff.y == py_ff) &&
                      (rd_data_ff.z == pz_ff);
   assign expired   = (now_ff >= rd_data_ff.expiry);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      kind_in      = kind_ff;
      exp_in       = exp_ff;
      entry_in     = entry_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      fading_in    = fading_ff;
      alpha_in     = alpha_ff;
      last_slot_in = last_slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      rd_addr = idx_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               now_in  = req_if.now;
               px_in   = req_if.pos_x;
               py_in   = req_if.pos_y;
               pz_in   = req_if.pos_z;
               kind_in = req_if.contact_kind;
               exp_in  = exp_sum[32] ? '1 : exp_sum[31:0];
               idx_in  = '0;
               if (req_if.cmd) begin
                  state_in = S_SW_START;
               end else if (count_ff >= MAX_CNT) begin
                  state_in = S_ADD_FULL;
               end else begin
                  state_in = S_ADD_SCAN;
               end
            end
         end

         S_ADD_FULL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_pkg::ST_FULL, slot: '0,
                          entry_count: cat_pkg::count_type'(count_ff),
                          out_x: '0, out_y: '0, out_z: '0, out_kind: '0,
                          alpha: '0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_ADD_SCAN: begin
            state_in = (idx_ff == count_ff) ? S_ADD_INS : S_ADD_CMP;
         end

         S_ADD_CMP: begin
            if (!pos_match) begin
               idx_in   = idx_ff + CNT_ONE;
               state_in = S_ADD_SCAN;
            end else if (out_free) begin
               // refresh: rewrite the entry with the new expiry
               wr_en          = 1'b1;
               wr_data.expiry = exp_ff;
               rsp_valid_in   = 1'b1;
               rsp_in = '{status: cat_pkg::ST_REFRESHED,
                          slot: cat_pkg::slot_type'(idx_ff),
                          entry_count: cat_pkg::count_type'(count_ff),
                          out_x: '0, out_y: '0, out_z: '0, out_kind: '0,
                          alpha: '0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_ADD_INS: begin
            if (out_free) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[IDX_W-1:0];
               wr_data = '{x: px_ff, y: py_ff, z: pz_ff, kind: kind_ff, expiry: exp_ff};
               count_in     = count_ff + CNT_ONE;
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_pkg::ST_INSERTED,
                          slot: cat_pkg::slot_type'(count_ff),
                          entry_count: cat_pkg::count_type'(count_ff + CNT_ONE),
                          out_x: '0, out_y: '0, out_z: '0, out_kind: '0,
                          alpha: '0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_SW_START: begin
            if (count_ff != '0) begin
               state_in = S_LS_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_pkg::ST_EMPTY, slot: '0, entry_count: '0,
                          out_x: '0, out_y: '0, out_z: '0, out_kind: '0,
                          alpha: '0, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         S_LS_RD: begin
            state_in = S_LS_D;
         end

         S_LS_D: begin
            entry_in = rd_data_ff;
            if (d_full < 32'(fade_eff)) begin
               d_in     = d_full[15:0];
               state_in = S_LS_MUL;
            end else begin
               quo_in    = base_alpha_ff;
               fading_in = 1'b0;
               state_in  = S_LS_OUT;
            end
         end

         S_LS_MUL: begin
            rem_in    = 24'(base_alpha_ff) * 24'(d_ff);
            quo_in    = '0;
            bit_in    = 3'd7;
            fading_in = 1'b1;
            state_in  = S_LS_DIV;
         end

         S_LS_DIV: begin
            rem_in = trial_ge ? (rem_ff - trial) : rem_ff;
            quo_in = {quo_ff[6:0], trial_ge};
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = S_LS_OUT;
            end
         end

         S_LS_OUT: begin
            if (idx_ff == count_ff - CNT_ONE) begin
               // hold the final listing until the expiry pass has run
               alpha_in     = alpha_now;
               last_slot_in = idx_ff[IDX_W-1:0];
               idx_in       = '0;
               state_in     = S_RM_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_pkg::ST_LISTED,
                          slot: cat_pkg::slot_type'(idx_ff),
                          entry_count: cat_pkg::count_type'(count_ff),
                          out_x: entry_ff.x, out_y: entry_ff.y, out_z: entry_ff.z,
                          out_kind: entry_ff.kind, alpha: alpha_now, last: 1'b0};
               idx_in   = idx_ff + CNT_ONE;
               state_in = S_LS_RD;
            end
         end

         // Entries below idx are live and untouched, so the first expired
         // entry is never below idx; a moved-in entry is checked again.
         S_RM_RD: begin
            state_in = (idx_ff == count_ff) ? S_FINAL : S_RM_CHK;
         end

         S_RM_CHK: begin
            if (expired) begin
               rd_addr  = IDX_W'(count_ff - CNT_ONE);
               state_in = S_RM_WR;
            end else begin
               idx_in   = idx_ff + CNT_ONE;
               state_in = S_RM_RD;
            end
         end

         S_RM_WR: begin
            wr_en    = 1'b1;
            count_in = count_ff - CNT_ONE;
            state_in = S_RM_RD;
         end

         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_pkg::ST_LISTED,
                          slot: cat_pkg::slot_type'(last_slot_ff),
                          entry_count: cat_pkg::count_type'(count_ff),
                          out_x: entry_ff.x, out_y: entry_ff.y, out_z: entry_ff.z,
                          out_kind: entry_ff.kind, alpha: alpha_ff, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      now_ff       <= now_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      kind_ff      <= kind_in;
      exp_ff       <= exp_in;
      entry_ff     <= entry_in;
      d_ff         <= d_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      bit_ff       <= bit_in;
      fading_ff    <= fading_in;
      alpha_ff     <= alpha_in;
      last_slot_ff <= last_slot_in;
      rsp_ff       <= rsp_in;
   end

   // ---------------------------------------------------------------- result port
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.slot        = rsp_ff.slot;
   assign rsp_if.entry_count = rsp_ff.entry_count;
   assign rsp_if.out_x       = rsp_ff.out_x;
   assign rsp_if.out_y       = rsp_ff.out_y;
   assign rsp_if.out_z       = rsp_ff.out_z;
   assign rsp_if.out_kind    = rsp_ff.out_kind;
   assign rsp_if.alpha       = rsp_ff.alpha;
   assign rsp_if.last        = rsp_ff.last;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count above table size");

   a_list_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LS_RD || state_ff == S_LS_D || state_ff == S_LS_MUL ||
       state_ff == S_LS_DIV || state_ff == S_LS_OUT) |-> idx_ff < count_ff)
      else $error("listing index past live entries");

   a_remove_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RM_WR) |=> count_ff == $past(count_ff) - CNT_ONE)
      else $error("removal did not drop the count by one");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != cat_pkg::ST_LISTED) |-> rsp_ff.last)
      else $error("single-result transfer without last");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && !req_if.cmd && count_ff >= MAX_CNT)
      |=> state_ff == S_ADD_FULL)
      else $error("add on full table not dropped");
`endif

endmodule
